[rtl/owbw_pkg.sv]
// ----------------------------------------------------------------------------
// owbw_pkg: shared types and constants for the one-wire backlight writer
// Holds the command classification, the configuration bundle, the queue
// status bundle and the brightness code table.
// ----------------------------------------------------------------------------
package owbw_pkg;

    // Width of the interval timer.
    localparam int TIMER_BITS = 16;
    localparam logic [31:0] TIMER_MAX32 = 32'((64'd1 << TIMER_BITS) - 64'd1);

    // Input operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;

    // Configuration register indexes.
    localparam logic [3:0] REG_SHUTDOWN  = 4'd0;
    localparam logic [3:0] REG_DDELAY    = 4'd1;
    localparam logic [3:0] REG_DLOW      = 4'd2;
    localparam logic [3:0] REG_DWINDOW   = 4'd3;
    localparam logic [3:0] REG_FRAMEEDGE = 4'd4;
    localparam logic [3:0] REG_SHORT     = 4'd5;
    localparam logic [3:0] REG_LONG      = 4'd6;
    localparam logic [3:0] REG_PASSES    = 4'd7;

    // Fixed protocol values.
    localparam logic [7:0] ADDR_BYTE = 8'h72;
    localparam logic [3:0] MAX_LEVEL = 4'd9;

    // Command queue depth.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [TIMER_BITS-1:0] t_timer;

    // Classified command kinds.
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SET,
        KIND_OFF,
        KIND_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] code;
    } t_cmd;

    typedef struct packed {
        logic [15:0] shutdown;
        logic [15:0] ddelay;
        logic [15:0] dlow;
        logic [15:0] dwindow;
        logic [15:0] frame_edge;
        logic [15:0] short_pulse;
        logic [15:0] long_pulse;
        logic [1:0]  passes;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Brightness level to 5-bit controller code.
    function automatic logic [4:0] level_code(input logic [3:0] lvl);
        logic [4:0] c;
        case (lvl)
            4'd0:    c = 5'd0;
            4'd1:    c = 5'd1;
            4'd2:    c = 5'd4;
            4'd3:    c = 5'd8;
            4'd4:    c = 5'd12;
            4'd5:    c = 5'd16;
            4'd6:    c = 5'd20;
            4'd7:    c = 5'd24;
            4'd8:    c = 5'd28;
            default: c = 5'd31;
        endcase
        return c;
    endfunction

    // Interval length: zero counts as one, long values saturate to the timer.
    function automatic t_timer sat_dur(input logic [15:0] dur);
        logic [31:0] d;
        d = {16'd0, dur};
        if (d == 32'd0) begin
            d = 32'd1;
        end
        if (d > TIMER_MAX32) begin
            d = TIMER_MAX32;
        end
        return d[TIMER_BITS-1:0];
    endfunction

endpackage

[rtl/owbw_front.sv]
// ----------------------------------------------------------------------------
// owbw_front: command intake
// Accepts input transactions, decodes the operation, clamps the level and
// looks up the controller code, then pushes the command into the queue.
// ----------------------------------------------------------------------------
module owbw_front (
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [3:0] level, [7:4] zero
    input  logic [1:0]        i_s_tuser,   // [1:0] operation
    input  owbw_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output owbw_pkg::t_cmd    o_cmd
);

    logic [1:0] op;
    logic [3:0] lvl;
    logic [3:0] lvl_clamped;

    assign op  = i_s_tuser;
    assign lvl = i_s_tdata[3:0];

    // Take a transaction whenever the queue has room.
    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && !i_q_stat.full;

    // Classify the operation and precompute the brightness code.
    always_comb begin
        lvl_clamped = (lvl > owbw_pkg::MAX_LEVEL) ? owbw_pkg::MAX_LEVEL : lvl;
        o_cmd.code  = owbw_pkg::level_code(lvl_clamped);
        case (op)
            owbw_pkg::OP_TICK: o_cmd.kind = owbw_pkg::KIND_TICK;
            owbw_pkg::OP_SET:  o_cmd.kind = owbw_pkg::KIND_SET;
            owbw_pkg::OP_OFF:  o_cmd.kind = owbw_pkg::KIND_OFF;
            default:           o_cmd.kind = owbw_pkg::KIND_NOP;
        endcase
    end

endmodule

[rtl/owbw_queue.sv]
// ----------------------------------------------------------------------------
// owbw_queue: command queue
// Small first-in first-out buffer between the intake and the sequencer so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module owbw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owbw_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output owbw_pkg::t_cmd    o_cmd,
    output owbw_pkg::t_q_stat o_stat
);

    owbw_pkg::t_cmd                  r_mem [owbw_pkg::QDEPTH];
    logic [owbw_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [owbw_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [owbw_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_stat.full  = (r_count == owbw_pkg::QCNT_W'(owbw_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == owbw_pkg::QPTR_W'(owbw_pkg::QDEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == owbw_pkg::QPTR_W'(owbw_pkg::QDEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + owbw_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - owbw_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/owbw_back.sv]
// ----------------------------------------------------------------------------
// owbw_back: waveform sequencer
// Executes one queued command per cycle while its result can be registered:
// ticks count down the current interval and step through entry sequence, byte
// framing and bit phases. Each command yields one result in the output register.
// ----------------------------------------------------------------------------
module owbw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  owbw_pkg::t_cfg    i_cfg,
    input  owbw_pkg::t_q_stat i_q_stat,
    input  owbw_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata    // [0] line_level, [1] busy_res, [7:2] zero
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SHUT,
        PH_DDELAY,
        PH_DLOW,
        PH_DWIN,
        PH_START,
        PH_BITLOW,
        PH_BITHIGH,
        PH_END
    } t_phase;

    t_phase               r_phase, n_phase;
    owbw_pkg::t_timer     r_time, n_time;
    logic [2:0]           r_bit_idx, n_bit_idx;
    logic [7:0]           r_shift, n_shift;
    logic                 r_code_byte, n_code_byte;
    logic [1:0]           r_passes, n_passes;
    logic [4:0]           r_code, n_code;
    logic                 r_pin, n_pin;
    logic                 r_out_valid;
    logic [1:0]           r_out_data;
    owbw_pkg::t_timer     time_dec;
    logic [7:0]           shift_next;
    logic [2:0]           bit_next;
    logic                 busy;

    // Pop a command whenever the output register is free or being drained.
    assign o_pop = !i_q_stat.empty && (!r_out_valid || i_m_tready);
    assign busy  = (r_phase != PH_IDLE);

    // Next sequencer state for the command at the queue head.
    always_comb begin
        n_phase     = r_phase;
        n_time      = r_time;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_code_byte = r_code_byte;
        n_passes    = r_passes;
        n_code      = r_code;
        n_pin       = r_pin;
        time_dec    = (r_time != '0) ? r_time - owbw_pkg::t_timer'(1) : r_time;
        shift_next  = {r_shift[6:0], 1'b0};
        bit_next    = r_bit_idx + 3'd1;
        case (i_cmd.kind)
            owbw_pkg::KIND_TICK: begin
                if (busy) begin
                    n_time = time_dec;
                    if (time_dec == '0) begin
                        case (r_phase)
                            PH_SHUT: begin
                                n_phase = PH_DDELAY;
                                n_pin   = 1'b1;
                                n_time  = owbw_pkg::sat_dur(i_cfg.ddelay);
                            end
                            PH_DDELAY: begin
                                n_phase = PH_DLOW;
                                n_pin   = 1'b0;
                                n_time  = owbw_pkg::sat_dur(i_cfg.dlow);
                            end
                            PH_DLOW: begin
                                n_phase = PH_DWIN;
                                n_pin   = 1'b1;
                                n_time  = owbw_pkg::sat_dur(i_cfg.dwindow);
                            end
                            PH_DWIN: begin
                                n_shift   = owbw_pkg::ADDR_BYTE;
                                n_bit_idx = 3'd0;
                                n_phase   = PH_START;
                                n_pin     = 1'b1;
                                n_time    = owbw_pkg::sat_dur(i_cfg.frame_edge);
                            end
                            PH_START: begin
                                n_phase = PH_BITLOW;
                                n_pin   = 1'b0;
                                n_time  = owbw_pkg::sat_dur(r_shift[7] ?
                                          i_cfg.short_pulse : i_cfg.long_pulse);
                            end
                            PH_BITLOW: begin
                                n_phase = PH_BITHIGH;
                                n_pin   = 1'b1;
                                n_time  = owbw_pkg::sat_dur(r_shift[7] ?
                                          i_cfg.long_pulse : i_cfg.short_pulse);
                            end
                            PH_BITHIGH: begin
                                n_shift   = shift_next;
                                n_bit_idx = bit_next;
                                n_pin     = 1'b0;
                                if (bit_next == 3'd0) begin
                                    n_phase = PH_END;
                                    n_time  = owbw_pkg::sat_dur(i_cfg.frame_edge);
                                end else begin
                                    n_phase = PH_BITLOW;
                                    n_time  = owbw_pkg::sat_dur(shift_next[7] ?
                                              i_cfg.short_pulse : i_cfg.long_pulse);
                                end
                            end
                            PH_END: begin
                                if (!r_code_byte) begin
                                    // Address byte done: send the code byte.
                                    n_code_byte = 1'b1;
                                    n_shift     = {3'd0, r_code};
                                    n_bit_idx   = 3'd0;
                                    n_phase     = PH_START;
                                    n_pin       = 1'b1;
                                    n_time      = owbw_pkg::sat_dur(i_cfg.frame_edge);
                                end else begin
                                    n_passes    = r_passes - 2'd1;
                                    n_code_byte = 1'b0;
                                    if (r_passes != 2'd1) begin
                                        // Next pass starts straight from end-low.
                                        n_phase = PH_SHUT;
                                        n_pin   = 1'b0;
                                        n_time  = owbw_pkg::sat_dur(i_cfg.shutdown);
                                    end else begin
                                        n_phase = PH_IDLE;
                                        n_pin   = 1'b1;
                                        n_time  = '0;
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_time  = '0;
                            end
                        endcase
                    end
                end
            end
            owbw_pkg::KIND_SET: begin
                if (!busy) begin
                    n_code      = i_cmd.code;
                    n_passes    = (i_cfg.passes == 2'd0) ? 2'd1 : i_cfg.passes;
                    n_code_byte = 1'b0;
                    n_phase     = PH_SHUT;
                    n_pin       = 1'b0;
                    n_time      = owbw_pkg::sat_dur(i_cfg.shutdown);
                end
            end
            owbw_pkg::KIND_OFF: begin
                if (!busy) begin
                    n_pin = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_code_byte <= 1'b0;
            r_passes    <= '0;
            r_code      <= '0;
            r_pin       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_time      <= n_time;
                r_bit_idx   <= n_bit_idx;
                r_shift     <= n_shift;
                r_code_byte <= n_code_byte;
                r_passes    <= n_passes;
                r_code      <= n_code;
                r_pin       <= n_pin;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {(n_phase != PH_IDLE), n_pin};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_data};

endmodule

[rtl/one_wire_backlight_writer_unit.sv]
// ----------------------------------------------------------------------------
// one_wire_backlight_writer_unit: single-wire backlight pin driver
// Turns tick, set-brightness and off commands into the pulse-width waveform
// of a one-wire backlight controller, one result per command.
// ----------------------------------------------------------------------------
// The block takes one command per clock while the queue has room and returns
// one result per command, in order, at a sustained rate of one per clock while
// the result side accepts. A command is held first in a two-entry queue and then
// in the sequencer's output register before its result is offered; the queue lets
// the input keep flowing for two commands while the result side is stalled. The
// sequencer retires each command as it pops it, so no command type costs more
// than another. Configuration is a plain register write that is always ready;
// write it only while the block is idle.
module one_wire_backlight_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [3:0] level, [7:4] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    owbw_pkg::t_cfg    r_cfg;
    owbw_pkg::t_q_stat q_stat;
    owbw_pkg::t_cmd    front_cmd;
    owbw_pkg::t_cmd    head_cmd;
    logic              push;
    logic              pop;
    logic              r_prev_busy;
    logic              out_xfer;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shutdown    <= 16'd3000;
            r_cfg.ddelay      <= 16'd200;
            r_cfg.dlow        <= 16'd500;
            r_cfg.dwindow     <= 16'd1000;
            r_cfg.frame_edge  <= 16'd10;
            r_cfg.short_pulse <= 16'd10;
            r_cfg.long_pulse  <= 16'd50;
            r_cfg.passes      <= 2'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owbw_pkg::REG_SHUTDOWN:  r_cfg.shutdown    <= i_cfg_data;
                owbw_pkg::REG_DDELAY:    r_cfg.ddelay      <= i_cfg_data;
                owbw_pkg::REG_DLOW:      r_cfg.dlow        <= i_cfg_data;
                owbw_pkg::REG_DWINDOW:   r_cfg.dwindow     <= i_cfg_data;
                owbw_pkg::REG_FRAMEEDGE: r_cfg.frame_edge  <= i_cfg_data;
                owbw_pkg::REG_SHORT:     r_cfg.short_pulse <= i_cfg_data;
                owbw_pkg::REG_LONG:      r_cfg.long_pulse  <= i_cfg_data;
                owbw_pkg::REG_PASSES:    r_cfg.passes      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    owbw_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    owbw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    owbw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Busy flag of the previous result transaction, for the end-of-write check.
    assign out_xfer = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_busy <= 1'b0;
        end else if (out_xfer) begin
            r_prev_busy <= o_m_tdata[1];
        end
    end

    // The queue can never report full and empty together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("command queue reports full and empty");

    // A write that finishes leaves the line high.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_prev_busy && !o_m_tdata[1]) |-> o_m_tdata[0])
        else $error("line not released high at end of write");

    // No result is offered right after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

    // Input is refused only when the queue is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_stat.full)
        else $error("input stalled with room in the queue");

endmodule
